// ----- hdl/eht_pkg.sv -----
`default_nettype none
package eht_pkg;

  typedef enum logic [1:0] {
    StGet      = 2'd0,
    StUpdated  = 2'd1,
    StInserted = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    OpGet = 1'b0,
    OpPut = 1'b1
  } op_e;

  localparam logic [0:0] CfgInitialDepth = 1'b0;
  localparam logic [0:0] CfgKeyBits      = 1'b1;

  typedef enum logic [3:0] {
    SClear, SIdle, SDir, SLd, SScan, SWrite, SResp,
    SSplitChk, SDbl, SNewClr, SCopyRd, SCopyWr, SDirUpd, SLdOld
  } state_e;

  typedef struct packed {
    logic [63:0] found_value;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [63:0] value;
  } request_t;

endpackage
`default_nettype wire

// ----- hdl/eht_if.sv -----
`default_nettype none
interface eht_req_if;
  import eht_pkg::*;
  logic     valid;
  logic     ready;
  request_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface eht_rsp_if;
  import eht_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/extendible_hash_table_top.sv -----
`default_nettype none
// Extendible hash table of 64-bit keys and values, one request at a time.
// Key and value slots live in one synchronous memory of one word per slot
// (key and value side by side); the directory and the per-segment local
// depths are small memories as well. A get or a put walks the bucket one
// slot per cycle from the registered memory output. After the request is
// accepted, the directory lookup (SDir), the depth lookup (SLd) and the
// read of the first slot (SWrite) come before the bucket scan (SScan) and
// the hand-over to the output register (SResp); a matching key ends the
// scan early, and a new request is taken only after that hand-over. The
// result sits in its own output register, so a stalled receiver holds back
// the next request only once that request has finished. A put into a full
// bucket splits the segment first: a check (SSplitChk), a directory
// doubling (SDbl) when needed, a sweep that clears the new segment slot
// by slot (SNewClr), a copy of the old segment that reads each slot and
// writes those that move (SCopyRd, SCopyWr), an update of every directory
// entry that moves to the new segment (SDirUpd) and a write of the old
// segment's depth (SLdOld); the put is then retried from the directory
// lookup. After reset, and after every write of initial_depth, a clearing
// pass visits every slot and directory entry before the first request is
// taken. Writing key_bits takes effect at once and keeps the stored
// contents.
module extendible_hash_table_top
  import eht_pkg::*;
#(
  parameter int MAX_GLOBAL_DEPTH  = 6,
  parameter int MAX_SEGMENTS      = 64,
  parameter int BUCKET_INDEX_BITS = 4,
  parameter int SLOTS_PER_BUCKET  = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_index_i,
  input  wire  [6:0]  cfg_wdata_i,
  eht_req_if.sink     req,
  eht_rsp_if.source   rsp
);

  localparam int DirEntries  = 1 << MAX_GLOBAL_DEPTH;
  localparam int BktPerSeg   = 1 << BUCKET_INDEX_BITS;
  localparam int SlotsPerSeg = BktPerSeg * SLOTS_PER_BUCKET;
  localparam int StoreDepth  = MAX_SEGMENTS * SlotsPerSeg;
  localparam int SegW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CntW   = $clog2(MAX_SEGMENTS + 1);
  localparam int DirW   = MAX_GLOBAL_DEPTH;
  localparam int DepthW = $clog2(MAX_GLOBAL_DEPTH + 1);
  localparam int SlotW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SlotCW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int AddrW  = $clog2(StoreDepth);
  localparam int SegOffW = $clog2(SlotsPerSeg);
  localparam int SweepW = (AddrW > DirW ? AddrW : DirW) + 1;
  localparam int DirCW  = DirW + 1;

  // Largest usable starting depth: 2^d must fit the segment pool.
  function automatic logic [DepthW-1:0] clamp_depth(input logic [2:0] v);
    int d;
    d = (int'(v) > MAX_GLOBAL_DEPTH) ? MAX_GLOBAL_DEPTH : int'(v);
    for (int i = 0; i < 13; i++) begin
      if (d > 0 && (1 << d) > MAX_SEGMENTS) d = d - 1;
    end
    return DepthW'(d);
  endfunction

  // Prefix of depth d just below bit key_bits (saturated to 64).
  function automatic logic [DirW-1:0] prefix_of(input logic [63:0] k,
                                                input logic [DepthW-1:0] d,
                                                input logic [6:0] kb);
    logic [6:0]  kbs;
    logic [6:0]  sh;
    logic [63:0] s;
    logic [DirW:0] m;
    kbs = (kb > 7'd64) ? 7'd64 : kb;
    sh  = (kbs > 7'(d)) ? kbs - 7'(d) : 7'd0;
    s   = k >> sh;
    m   = (DirCW'(1) << d) - DirCW'(1);
    if (d == '0) return '0;
    return s[DirW-1:0] & m[DirW-1:0];
  endfunction

  state_e state_q, state_d;

  // Memories.
  logic [127:0]     store_mem [StoreDepth];
  logic [SegW-1:0]  dir_mem   [DirEntries];
  logic [DepthW-1:0] ld_mem   [MAX_SEGMENTS];

  logic             st_we;
  logic [AddrW-1:0] st_waddr, st_raddr;
  logic [127:0]     st_wdata, st_rdata_q;
  logic             dir_we;
  logic [DirW-1:0]  dir_waddr, dir_raddr;
  logic [SegW-1:0]  dir_wdata, dir_rdata_q;
  logic             ld_we;
  logic [SegW-1:0]  ld_waddr, ld_raddr;
  logic [DepthW-1:0] ld_wdata, ld_rdata_q;

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    st_rdata_q <= store_mem[st_raddr];
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    dir_rdata_q <= dir_mem[dir_raddr];
    if (ld_we) ld_mem[ld_waddr] <= ld_wdata;
    ld_rdata_q <= ld_mem[ld_raddr];
  end

  // Control and payload registers.
  logic [DepthW-1:0] gd_q, gd_d, ld_q, ld_d;
  logic [6:0]        kb_q, kb_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [SweepW-1:0] sw_q, sw_d;
  logic [SlotCW-1:0] j_q, j_d, cnt_q, cnt_d;
  logic [SlotW-1:0]  place_q, place_d;
  logic              has_place_q, has_place_d;
  logic [SegW-1:0]   seg_q, seg_d, nseg_q, nseg_d;
  logic [DirW-1:0]   di_q, di_d;
  logic [DirCW-1:0]  mid_q, mid_d, right_q, right_d;
  request_t          r_q, r_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              rv_q, rv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      gd_q <= '0; kb_q <= 7'd64; used_q <= CntW'(1);
      sw_q <= '0; rv_q <= 1'b0; nseg_q <= '0;
    end else begin
      state_q <= state_d;
      gd_q <= gd_d; kb_q <= kb_d; used_q <= used_d;
      sw_q <= sw_d; rv_q <= rv_d; nseg_q <= nseg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_q <= ld_d; j_q <= j_d; cnt_q <= cnt_d; place_q <= place_d;
    has_place_q <= has_place_d; seg_q <= seg_d; di_q <= di_d;
    mid_q <= mid_d; right_q <= right_d; r_q <= r_d; res_q <= res_d;
    out_q <= out_d;
  end

  logic [BUCKET_INDEX_BITS-1:0] bkt;
  logic [AddrW-1:0] base;
  logic [63:0]      sk, sv;
  logic [DirW-1:0]  sp;
  logic [DirW-1:0]  dir_sw;
  logic [SegOffW-1:0] off;
  logic [DirW-1:0]  stride;

  assign bkt  = r_q.key[BUCKET_INDEX_BITS-1:0];
  assign base = AddrW'((int'(seg_q) * BktPerSeg + int'(bkt)) * SLOTS_PER_BUCKET);
  assign sk   = st_rdata_q[127:64];
  assign sv   = st_rdata_q[63:0];
  assign sp   = prefix_of(sk, gd_q, kb_q);
  assign dir_sw = sw_q[DirW-1:0];
  assign off  = sw_q[SegOffW-1:0];
  assign stride = DirW'((DirCW'(1) << (gd_q - ld_q)) - DirCW'(1));

  assign req.ready   = (state_q == SIdle);
  assign rsp.valid   = rv_q;
  assign rsp.payload = out_q;

  always_comb begin
    state_d = state_q;
    gd_d = gd_q; kb_d = kb_q; used_d = used_q; sw_d = sw_q;
    ld_d = ld_q; j_d = j_q; cnt_d = cnt_q; place_d = place_q;
    has_place_d = has_place_q; seg_d = seg_q; nseg_d = nseg_q; di_d = di_q;
    mid_d = mid_q; right_d = right_q; r_d = r_q; res_d = res_q; rv_d = rv_q;
    out_d = out_q;
    st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = base;
    dir_we = 1'b0; dir_waddr = '0; dir_wdata = '0; dir_raddr = di_q;
    ld_we = 1'b0; ld_waddr = '0; ld_wdata = '0; ld_raddr = seg_q;

    if (rv_q && rsp.ready) rv_d = 1'b0;

    unique case (state_q)
      SClear: begin
        // Clear one slot a cycle and, within their ranges, set one directory entry
        // and one depth (gd_q for segments below 2^gd_q, else zero). Directory
        // entry i gets segment i modulo the pool size, counted in nseg_q.
        st_we = 1'b1; st_waddr = sw_q[AddrW-1:0];
        if (int'(sw_q) < DirEntries) begin
          dir_we = 1'b1; dir_waddr = dir_sw;
          dir_wdata = nseg_q;
          nseg_d = (int'(nseg_q) == MAX_SEGMENTS - 1) ? '0 : nseg_q + SegW'(1);
        end
        if (int'(sw_q) < MAX_SEGMENTS) begin
          ld_we = 1'b1; ld_waddr = sw_q[SegW-1:0];
          ld_wdata = (int'(sw_q) < (1 << gd_q)) ? gd_q : '0;
        end
        if (int'(sw_q) >= StoreDepth - 1 && int'(sw_q) >= DirEntries - 1
            && int'(sw_q) >= MAX_SEGMENTS - 1) begin
          state_d = SIdle; sw_d = '0;
        end else begin
          sw_d = sw_q + SweepW'(1);
        end
      end
      SIdle: begin
        if (req.valid && req.ready) begin
          r_d = req.payload; state_d = SDir;
        end
      end
      SDir: begin
        di_d = prefix_of(r_q.key, gd_q, kb_q);
        dir_raddr = prefix_of(r_q.key, gd_q, kb_q);
        state_d = SLd;
      end
      SLd: begin
        seg_d = dir_rdata_q; ld_raddr = dir_rdata_q;
        j_d = '0; has_place_d = 1'b0; place_d = '0;
        state_d = SWrite;
      end
      SWrite: begin
        // Issue the read of the first slot.
        ld_d = ld_rdata_q;
        st_raddr = base;
        state_d = SScan;
      end
      SScan: begin
        st_raddr = base + AddrW'(j_q) + AddrW'(1);
        if (sk == r_q.key) begin
          if (r_q.op == OpGet) begin
            res_d = '{found_value: sv, status: StGet};
          end else begin
            st_we = 1'b1; st_waddr = base + AddrW'(j_q);
            st_wdata = {r_q.key, r_q.value};
            res_d = '{found_value: '0, status: StUpdated};
          end
          state_d = SResp;
        end else begin
          if (!has_place_q && ((sk == '0 && sv == '0) ||
              prefix_of(sk, ld_q, kb_q) != prefix_of(r_q.key, ld_q, kb_q))) begin
            has_place_d = 1'b1; place_d = SlotW'(j_q);
          end
          if (int'(j_q) == SLOTS_PER_BUCKET - 1) begin
            if (r_q.op == OpGet) begin
              res_d = '{found_value: '0, status: StGet};
              state_d = SResp;
            end else if (has_place_d) begin
              st_we = 1'b1; st_waddr = base + AddrW'(place_d);
              st_wdata = {r_q.key, r_q.value};
              res_d = '{found_value: '0, status: StInserted};
              state_d = SResp;
            end else begin
              state_d = SSplitChk;
            end
          end
          j_d = j_q + SlotCW'(1);
        end
      end
      SResp: begin
        // The previous result may still wait; it moves on once taken.
        if (!rv_q || rsp.ready) begin
          rv_d = 1'b1; out_d = res_q; state_d = SIdle;
        end
      end
      SSplitChk: begin
        if (int'(used_q) >= MAX_SEGMENTS ||
            (ld_q >= gd_q && int'(gd_q) >= MAX_GLOBAL_DEPTH)) begin
          res_d = '{found_value: '0, status: StFull};
          state_d = SResp;
        end else if (ld_q >= gd_q) begin
          gd_d = gd_q + DepthW'(1);
          di_d = DirW'({di_q, 1'b0});
          ld_d = gd_q;
          sw_d = SweepW'((1 << (gd_q + DepthW'(1))) - 1);
          dir_raddr = DirW'((1 << (gd_q + DepthW'(1))) - 1) >> 1;
          state_d = SDbl;
        end else begin
          sw_d = '0; nseg_d = SegW'(used_q);
          state_d = SNewClr;
          mid_d = DirCW'(di_q & ~stride) + (DirCW'(stride) + DirCW'(1)) / 2;
          right_d = DirCW'(di_q & ~stride) + DirCW'(stride) + DirCW'(1);
        end
      end
      SDbl: begin
        // Walk down: entry i takes entry i/2; read of i/2 was issued last cycle.
        dir_we = 1'b1; dir_waddr = dir_sw; dir_wdata = dir_rdata_q;
        dir_raddr = DirW'(dir_sw - DirW'(1)) >> 1;
        if (sw_q == '0) begin
          sw_d = '0; nseg_d = SegW'(used_q);
          mid_d = DirCW'(di_q & ~stride) + (DirCW'(stride) + DirCW'(1)) / 2;
          right_d = DirCW'(di_q & ~stride) + DirCW'(stride) + DirCW'(1);
          state_d = SNewClr;
        end else begin
          sw_d = sw_q - SweepW'(1);
        end
      end
      SNewClr: begin
        st_we = 1'b1;
        st_waddr = AddrW'(int'(nseg_q) * SlotsPerSeg) + AddrW'(off);
        if (int'(sw_q) == SlotsPerSeg - 1) begin
          sw_d = '0; cnt_d = '0; j_d = '0; state_d = SCopyRd;
        end else begin
          sw_d = sw_q + SweepW'(1);
        end
      end
      SCopyRd: begin
        st_raddr = AddrW'(int'(seg_q) * SlotsPerSeg) + AddrW'(off);
        state_d = SCopyWr;
      end
      SCopyWr: begin
        // j_q is the slot within the bucket, so off - j_q is the bucket start.
        if (DirCW'(sp) >= mid_q && DirCW'(sp) < right_q) begin
          st_we = 1'b1;
          st_waddr = AddrW'(int'(nseg_q) * SlotsPerSeg) + AddrW'(off)
                   - AddrW'(j_q) + AddrW'(cnt_q);
          st_wdata = st_rdata_q;
          cnt_d = cnt_q + SlotCW'(1);
        end
        if (int'(j_q) == SLOTS_PER_BUCKET - 1) begin
          j_d = '0; cnt_d = '0;
        end else begin
          j_d = j_q + SlotCW'(1);
        end
        if (int'(sw_q) == SlotsPerSeg - 1) begin
          sw_d = SweepW'(mid_q); state_d = SDirUpd;
        end else begin
          sw_d = sw_q + SweepW'(1); state_d = SCopyRd;
        end
      end
      SDirUpd: begin
        dir_we = 1'b1; dir_waddr = dir_sw; dir_wdata = nseg_q;
        if (DirCW'(sw_q) + DirCW'(1) >= right_q) begin
          ld_we = 1'b1; ld_waddr = nseg_q; ld_wdata = ld_q + DepthW'(1);
          used_d = used_q + CntW'(1);
          sw_d = '0;
          state_d = SLdOld;
        end else begin
          sw_d = sw_q + SweepW'(1);
        end
      end
      SLdOld: begin
        // The old segment takes the deeper depth too, then the put retries.
        ld_we = 1'b1; ld_waddr = seg_q; ld_wdata = ld_q + DepthW'(1);
        state_d = SDir;
      end
      default: state_d = SIdle;
    endcase

    // The user must write configuration only while idle; the block itself does not enforce it.
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgInitialDepth: begin
          gd_d = clamp_depth(cfg_wdata_i[2:0]);
          used_d = CntW'(1 << clamp_depth(cfg_wdata_i[2:0]));
          sw_d = '0; nseg_d = '0; state_d = SClear;
        end
        CfgKeyBits: kb_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("response dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> $stable(rsp.payload))
    else $error("response changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(used_q) <= MAX_SEGMENTS)
    else $error("segment count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(gd_q) <= MAX_GLOBAL_DEPTH)
    else $error("global depth overflow");

endmodule
`default_nettype wire
